[rtl/tcw_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared constants, codes and types of the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

  localparam int COLUMNS    = 80;
  localparam int ROWS       = 25;
  localparam int CELL_TOTAL = COLUMNS * ROWS;
  localparam int CELL_W     = $clog2(CELL_TOTAL);
  localparam int COL_W      = $clog2(COLUMNS);

  typedef logic [CELL_W-1:0] cell_t;
  typedef logic [COL_W-1:0]  col_t;

  localparam cell_t CELL_COLS   = cell_t'(COLUMNS);
  localparam cell_t CELL_ROW2   = cell_t'(2 * COLUMNS);
  localparam cell_t CELL_BOTTOM = cell_t'(CELL_TOTAL - COLUMNS);
  localparam cell_t CELL_LAST   = cell_t'(CELL_TOTAL - 1);
  localparam col_t  COL_LAST    = col_t'(COLUMNS - 1);

  // operations
  localparam logic [1:0] OP_PUT   = 2'd0;
  localparam logic [1:0] OP_CLEAR = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [7:0]  CH_BS      = 8'h08;
  localparam logic [7:0]  CH_NL      = 8'h0A;
  localparam logic [7:0]  CH_SPACE   = 8'h20;
  localparam logic [7:0]  ATTR_BLANK = 8'h0F;
  localparam logic [15:0] BLANK_CELL = {ATTR_BLANK, CH_SPACE};

  // cursor commands
  typedef logic [2:0] cur_cmd_t;
  localparam cur_cmd_t CUR_HOLD = 3'd0;
  localparam cur_cmd_t CUR_BACK = 3'd1;
  localparam cur_cmd_t CUR_NEXT = 3'd2;
  localparam cur_cmd_t CUR_LINE = 3'd3;
  localparam cur_cmd_t CUR_HOME = 3'd4;

  typedef struct packed {
    cell_t pos;
    logic  at_home;
    logic  last_cell;
    logic  last_row;
  } cur_stat_t;

endpackage

[rtl/tcw_cursor.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_cursor
// Cursor register kept as cell index plus column, so no division is needed.
// ----------------------------------------------------------------------------
module tcw_cursor
  import tcw_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  cur_cmd_t  cmd,
  output cur_stat_t stat
);

  cell_t cell_r, cell_nxt;
  col_t  col_r, col_nxt;

  assign stat.pos       = cell_r;
  assign stat.at_home   = (cell_r <= CELL_COLS);
  assign stat.last_cell = (cell_r == CELL_LAST);
  assign stat.last_row  = (cell_r >= CELL_BOTTOM);

  always_comb begin
    cell_nxt = cell_r;
    col_nxt  = col_r;
    unique case (cmd)
      CUR_HOLD: begin
      end
      CUR_BACK: begin
        cell_nxt = cell_r - cell_t'(1);
        col_nxt  = (col_r == '0) ? COL_LAST : col_r - col_t'(1);
      end
      CUR_NEXT: begin
        // running off the last cell lands on the start of the bottom row
        if (stat.last_cell) begin
          cell_nxt = CELL_BOTTOM;
          col_nxt  = '0;
        end else begin
          cell_nxt = cell_r + cell_t'(1);
          col_nxt  = (col_r == COL_LAST) ? '0 : col_r + col_t'(1);
        end
      end
      CUR_LINE: begin
        cell_nxt = stat.last_row ? CELL_BOTTOM : cell_r - cell_t'(col_r) + CELL_COLS;
        col_nxt  = '0;
      end
      CUR_HOME: begin
        cell_nxt = CELL_COLS;
        col_nxt  = '0;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_r <= CELL_COLS;
      col_r  <= '0;
    end else begin
      cell_r <= cell_nxt;
      col_r  <= col_nxt;
    end
  end

  a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
    (cell_r >= CELL_COLS) && (cell_r <= CELL_LAST))
    else $error("cursor left the text area");

  a_cursor_home: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd == CUR_HOME) |=> (cell_r == CELL_COLS) && (col_r == '0))
    else $error("cursor not homed");

endmodule

[rtl/text_console_writer.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_writer
// 80 by 25 text console kept in one cell memory with a sequencer around it.
// ----------------------------------------------------------------------------
// A put that needs no scroll, and an unused op, keep busy low and the result
// strobe follows in the next cycle, so such words can be issued back to back.
// A read passes through S_READ for the registered memory read. A put that
// runs past the bottom row scrolls and a clear blanks the text area; both run
// through the single write port of the cell memory, one cell per cycle, where
// a pending row shift takes the port first. After reset a clearing pass blanks
// the memory with busy high. Results cannot be stalled: out_valid is high for
// exactly one cycle per word and must be taken then.
module text_console_writer
  import tcw_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  in_op,
  input  logic [7:0]  in_char_code,
  input  logic [7:0]  in_color,
  input  logic [10:0] in_cell_index,
  output logic        out_valid,
  output logic [10:0] out_cursor_cell,
  output logic [7:0]  out_read_char,
  output logic [7:0]  out_read_attr
);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_READ   = 2'd1;
  localparam logic [1:0] S_SCROLL = 2'd2;
  localparam logic [1:0] S_BLANK  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  cell_t       addr_r, addr_nxt;
  logic        emit_r, emit_nxt;
  logic        mv_r, mv_nxt;
  cell_t       mv_addr_r, mv_addr_nxt;
  logic        rd_ok_r, rd_ok_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [7:0]  out_char_r, out_char_nxt;
  logic [7:0]  out_attr_r, out_attr_nxt;
  logic [15:0] rdata_r;

  logic        we;
  cell_t       waddr, raddr;
  logic [15:0] wdata;
  logic        accept;

  cur_cmd_t    cur_cmd;
  cur_stat_t   cur;

  logic [15:0] mem [CELL_TOTAL];

  tcw_cursor u_cursor (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cur_cmd),
    .stat  (cur)
  );

  assign busy   = (state_r != S_IDLE);
  assign accept = start && !busy;

  always_comb begin
    state_nxt     = state_r;
    addr_nxt      = addr_r;
    emit_nxt      = emit_r;
    mv_nxt        = 1'b0;
    mv_addr_nxt   = mv_addr_r;
    rd_ok_nxt     = rd_ok_r;
    out_valid_nxt = 1'b0;
    out_char_nxt  = out_char_r;
    out_attr_nxt  = out_attr_r;
    cur_cmd       = CUR_HOLD;
    raddr         = addr_r;
    // the shifted cell from last cycle's read has the write port first
    we            = mv_r;
    waddr         = mv_addr_r;
    wdata         = rdata_r;

    unique case (state_r)
      S_IDLE: begin
        raddr = (32'(in_cell_index) < CELL_TOTAL) ? cell_t'(in_cell_index) : '0;
        if (accept) begin
          out_char_nxt = '0;
          out_attr_nxt = '0;
          emit_nxt     = 1'b1;
          case (in_op)
            OP_PUT: begin
              if (in_char_code == CH_BS) begin
                out_valid_nxt = 1'b1;
                if (!cur.at_home) begin
                  cur_cmd = CUR_BACK;
                  we      = 1'b1;
                  waddr   = cur.pos - cell_t'(1);
                  wdata   = BLANK_CELL;
                end
              end else if (in_char_code == CH_NL) begin
                cur_cmd = CUR_LINE;
                if (cur.last_row) begin
                  state_nxt = S_SCROLL;
                  addr_nxt  = CELL_ROW2;
                end else begin
                  out_valid_nxt = 1'b1;
                end
              end else begin
                cur_cmd = CUR_NEXT;
                we      = 1'b1;
                waddr   = cur.pos;
                wdata   = {in_color, in_char_code};
                if (cur.last_cell) begin
                  state_nxt = S_SCROLL;
                  addr_nxt  = CELL_ROW2;
                end else begin
                  out_valid_nxt = 1'b1;
                end
              end
            end
            OP_CLEAR: begin
              cur_cmd   = CUR_HOME;
              state_nxt = S_BLANK;
              addr_nxt  = CELL_COLS;
            end
            OP_READ: begin
              rd_ok_nxt = (32'(in_cell_index) < CELL_TOTAL);
              state_nxt = S_READ;
            end
            default: begin
              out_valid_nxt = 1'b1;
            end
          endcase
        end
      end
      S_READ: begin
        out_valid_nxt = 1'b1;
        out_char_nxt  = rd_ok_r ? rdata_r[7:0] : '0;
        out_attr_nxt  = rd_ok_r ? rdata_r[15:8] : '0;
        state_nxt     = S_IDLE;
      end
      S_SCROLL: begin
        // read one row down, write it back in the next cycle one row up
        mv_nxt      = 1'b1;
        mv_addr_nxt = addr_r - CELL_COLS;
        if (addr_r == CELL_LAST) begin
          state_nxt = S_BLANK;
          addr_nxt  = CELL_BOTTOM;
        end else begin
          addr_nxt = addr_r + cell_t'(1);
        end
      end
      S_BLANK: begin
        if (!mv_r) begin
          we    = 1'b1;
          waddr = addr_r;
          wdata = BLANK_CELL;
          if (addr_r == CELL_LAST) begin
            state_nxt     = S_IDLE;
            out_valid_nxt = emit_r;
          end else begin
            addr_nxt = addr_r + cell_t'(1);
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_BLANK;
      addr_r      <= '0;
      emit_r      <= 1'b0;
      mv_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      addr_r      <= addr_nxt;
      emit_r      <= emit_nxt;
      mv_r        <= mv_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    mv_addr_r  <= mv_addr_nxt;
    rd_ok_r    <= rd_ok_nxt;
    out_char_r <= out_char_nxt;
    out_attr_r <= out_attr_nxt;
  end

  assign out_valid       = out_valid_r;
  assign out_cursor_cell = 11'(cur.pos);
  assign out_read_char   = out_char_r;
  assign out_read_attr   = out_attr_r;

  a_idle_no_shift: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !mv_r)
    else $error("row shift still pending while idle");

  a_read_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_READ) |=> out_valid_r)
    else $error("read word produced no result");

  a_reset_sweep: assert property (@(posedge clk)
    $rose(rst_n) |-> busy && !out_valid_r)
    else $error("clearing pass missing after reset");

endmodule

[verif/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text console writer. A shadow copy of the cell
// memory and cursor predicts every result word; puts, clears, reads, scrolls,
// backspaces and stray ops are driven with random gaps and compared field by
// field as the result strobes come back.
// ----------------------------------------------------------------------------
module testbench;
  import tcw_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam int RANDOM_WORDS = 1950;
  localparam int TAIL_CYCLES  = 40;

  typedef struct {
    logic [1:0]  op;
    logic [7:0]  ch;
    logic [7:0]  color;
    logic [10:0] idx;
    bit          wait_idle;
  } console_cmd_t;

  typedef struct packed {
    cell_t      cursor_cell;
    logic [7:0] read_char;
    logic [7:0] read_attr;
  } console_view_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic [1:0]  in_op = '0;
  logic [7:0]  in_char_code = '0;
  logic [7:0]  in_color = '0;
  logic [10:0] in_cell_index = '0;
  logic        out_valid;
  logic [10:0] out_cursor_cell;
  logic [7:0]  out_read_char;
  logic [7:0]  out_read_attr;

  console_cmd_t  cmd_queue[$];
  console_view_t expected_views[$];
  logic [15:0]   shadow_cells [CELL_TOTAL];
  int            shadow_cursor;
  int            issued_count = 0;
  int            accepted_count = 0;
  int            error_count = 0;
  int            hold_cycles = 0;
  int            calm_left = 0;
  bit            drain_next = 1'b0;

  text_console_writer dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .start          (start),
    .busy           (busy),
    .in_op          (in_op),
    .in_char_code   (in_char_code),
    .in_color       (in_color),
    .in_cell_index  (in_cell_index),
    .out_valid      (out_valid),
    .out_cursor_cell(out_cursor_cell),
    .out_read_char  (out_read_char),
    .out_read_attr  (out_read_attr)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // rows 2..last move up one row once the cursor runs off the screen
  function automatic void scroll_if_past_end();
    if (shadow_cursor >= CELL_TOTAL) begin
      for (int i = COLUMNS; i + COLUMNS < CELL_TOTAL; i++)
        shadow_cells[i] = shadow_cells[i + COLUMNS];
      for (int i = CELL_TOTAL - COLUMNS; i < CELL_TOTAL; i++)
        shadow_cells[i] = BLANK_CELL;
      shadow_cursor -= COLUMNS;
    end
  endfunction

  function automatic console_view_t predict_console(logic [1:0] op, logic [7:0] ch,
                                                    logic [7:0] color, logic [10:0] idx);
    console_view_t v;
    v.read_char = '0;
    v.read_attr = '0;
    case (op)
      OP_PUT: begin
        scroll_if_past_end();
        if (ch == CH_BS) begin
          // backspace never reaches into the status row
          if (shadow_cursor > COLUMNS) begin
            shadow_cursor--;
            shadow_cells[shadow_cursor] = BLANK_CELL;
          end
        end else if (ch == CH_NL) begin
          shadow_cursor = (shadow_cursor / COLUMNS + 1) * COLUMNS;
        end else begin
          shadow_cells[shadow_cursor] = {color, ch};
          shadow_cursor++;
        end
        scroll_if_past_end();
      end
      OP_CLEAR: begin
        for (int i = COLUMNS; i < CELL_TOTAL; i++)
          shadow_cells[i] = BLANK_CELL;
        shadow_cursor = COLUMNS;
      end
      OP_READ: begin
        if (idx < CELL_TOTAL) begin
          v.read_char = shadow_cells[idx][7:0];
          v.read_attr = shadow_cells[idx][15:8];
        end
      end
      default: ;
    endcase
    v.cursor_cell = cell_t'(shadow_cursor);
    return v;
  endfunction

  // mostly back to back, a few short gaps, rare long ones, and calm stretches
  function automatic int pick_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (calm_left > 0) begin
      calm_left--;
      return 0;
    end
    if (roll < 3) begin
      calm_left = $urandom_range(40, 120);
      return 0;
    end
    if (roll < 60) return 0;
    if (roll < 88) return $urandom_range(1, 3);
    if (roll < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 80);
  endfunction

  task automatic queue_cmd(input logic [1:0] op, input logic [7:0] ch,
                           input logic [7:0] color, input logic [10:0] idx);
    console_cmd_t c;
    c.op = op;
    c.ch = ch;
    c.color = color;
    c.idx = idx;
    c.wait_idle = drain_next;
    drain_next = 1'b0;
    cmd_queue.push_back(c);
  endtask

  // driver: a new word goes out once the previous one has been taken
  always @(negedge clk) begin
    console_cmd_t c;
    if (rst_n && accepted_count == issued_count) begin
      if (hold_cycles > 0) begin
        hold_cycles--;
        start <= 1'b0;
      end else if (cmd_queue.size() > 0 &&
                   !(cmd_queue[0].wait_idle && expected_views.size() > 0)) begin
        c = cmd_queue.pop_front();
        in_op <= c.op;
        in_char_code <= c.ch;
        in_color <= c.color;
        in_cell_index <= c.idx;
        start <= 1'b1;
        issued_count++;
        hold_cycles = pick_gap();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: check result words, then predict for a word taken at this edge
  always @(posedge clk) begin
    console_view_t want;
    if (rst_n) begin
      if (out_valid) begin
        if (expected_views.size() == 0) begin
          $error("result word with none expected: cursor_cell %0d", out_cursor_cell);
          error_count++;
        end else begin
          want = expected_views.pop_front();
          if (out_cursor_cell !== want.cursor_cell) begin
            $error("cursor_cell: expected %0d, got %0d", want.cursor_cell, out_cursor_cell);
            error_count++;
          end
          if (out_read_char !== want.read_char) begin
            $error("read_char: expected 0x%02h, got 0x%02h", want.read_char, out_read_char);
            error_count++;
          end
          if (out_read_attr !== want.read_attr) begin
            $error("read_attr: expected 0x%02h, got 0x%02h", want.read_attr, out_read_attr);
            error_count++;
          end
        end
      end
      if (start && !busy) begin
        expected_views.push_back(predict_console(in_op, in_char_code, in_color, in_cell_index));
        accepted_count++;
      end
    end
  end

  initial begin
    #(200_000_000);
    $display("Simulation FAILED");
    $finish;
  end

  initial begin
    int queued;
    int kind;
    int len;
    logic [7:0] hue;

    for (int i = 0; i < CELL_TOTAL; i++)
      shadow_cells[i] = BLANK_CELL;
    shadow_cursor = COLUMNS;

    // directed words
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd0);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd1999);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd2000);
    queue_cmd(OP_READ, 8'hFF, 8'hFF, 11'd2047);
    queue_cmd(OP_PUT, CH_BS, 8'h55, 11'd0);          // backspace at home
    queue_cmd(OP_PUT, 8'h00, 8'h00, 11'd0);
    queue_cmd(OP_PUT, 8'hFF, 8'hFF, 11'd2047);
    queue_cmd(OP_PUT, 8'h41, 8'h5A, 11'd0);
    queue_cmd(OP_PUT, CH_BS, 8'hAA, 11'd0);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd80);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd81);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd82);
    queue_cmd(OP_PUT, CH_NL, 8'h00, 11'd0);
    queue_cmd(OP_PUT, CH_NL, 8'hFF, 11'd0);
    queue_cmd(OP_PUT, CH_SPACE, ATTR_BLANK, 11'd0);
    queue_cmd(OP_UNUSED, 8'hFF, 8'hFF, 11'd2047);
    queue_cmd(OP_UNUSED, 8'h00, 8'h00, 11'd0);
    queue_cmd(OP_CLEAR, 8'hFF, 8'hFF, 11'd2047);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd80);
    queue_cmd(OP_READ, 8'h00, 8'h00, 11'd160);
    queue_cmd(OP_PUT, CH_BS, 8'h00, 11'd0);

    // random part: text lines, reads, backspace runs, newline bursts, noise
    drain_next = 1'b1;
    queued = 0;
    while (queued < RANDOM_WORDS) begin
      kind = $urandom_range(0, 99);
      if ($urandom_range(0, 49) == 0) drain_next = 1'b1;
      if (kind < 55) begin
        kind = $urandom_range(0, 9);
        len = (kind < 7) ? $urandom_range(0, 12) :
              (kind < 9) ? $urandom_range(13, 60) : $urandom_range(61, 170);
        hue = $urandom_range(0, 255);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 4) == 0) hue = $urandom_range(0, 255);
          if ($urandom_range(0, 9) == 0)
            queue_cmd(OP_PUT, CH_BS, hue, cell_t'($urandom_range(0, 2047)));
          else
            queue_cmd(OP_PUT, 8'($urandom_range(0, 255)), hue,
                      cell_t'($urandom_range(0, 2047)));
        end
        if ($urandom_range(0, 99) < 85)
          queue_cmd(OP_PUT, CH_NL, 8'($urandom_range(0, 255)), cell_t'($urandom_range(0, 2047)));
        queued += len + 1;
      end else if (kind < 72) begin
        len = $urandom_range(1, 6);
        for (int k = 0; k < len; k++) begin
          if ($urandom_range(0, 9) == 0)
            queue_cmd(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      cell_t'($urandom_range(CELL_TOTAL, 2047)));
          else
            queue_cmd(OP_READ, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                      cell_t'($urandom_range(0, CELL_TOTAL - 1)));
        end
        queued += len;
      end else if (kind < 80) begin
        // long runs cross row boundaries and pile up at home
        len = $urandom_range(1, 90);
        for (int k = 0; k < len; k++)
          queue_cmd(OP_PUT, CH_BS, 8'($urandom_range(0, 255)), cell_t'($urandom_range(0, 2047)));
        queued += len;
      end else if (kind < 85) begin
        len = $urandom_range(1, 30);
        for (int k = 0; k < len; k++)
          queue_cmd(OP_PUT, CH_NL, 8'($urandom_range(0, 255)), cell_t'($urandom_range(0, 2047)));
        queued += len;
      end else if (kind < 88) begin
        queue_cmd(OP_CLEAR, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  cell_t'($urandom_range(0, 2047)));
        queued++;
      end else if (kind < 91) begin
        queue_cmd(OP_UNUSED, 8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                  cell_t'($urandom_range(0, 2047)));
        queued++;
      end else begin
        queue_cmd(2'($urandom_range(0, 3)), 8'($urandom_range(0, 255)),
                  8'($urandom_range(0, 255)), cell_t'($urandom_range(0, 2047)));
        queued++;
      end
    end

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    while (cmd_queue.size() != 0 || accepted_count != issued_count ||
           expected_views.size() != 0)
      @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);

    if (error_count == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule

[text_console_writer.f]
rtl/tcw_pkg.sv
rtl/tcw_cursor.sv
rtl/text_console_writer.sv
verif/testbench.sv
